[hdl/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants for the min-heap priority queue
// Holds the capacity, the derived widths, the opcode and status codes, the
// controller states and the command and status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// Number of keys the heap can hold; slots 1..CAPACITY are used.
	localparam int CAPACITY = 255;

	// Width of the entry count, which is also the width of a slot address.
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = CNT_W;
	localparam int DEPTH  = CAPACITY + 1;
	localparam int KEY_W  = 32;
	localparam int COUNT_W = 8;

	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CHECK,
		S_UP_CMP,
		S_RM_LOAD,
		S_DN_CHECK,
		S_DN_CMP,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // latch a new request
		logic up_check;  // sift up: write at root or read the parent
		logic up_cmp;    // sift up: compare with the parent and write
		logic rm_load;   // capture the root and the last entry
		logic dn_check;  // sift down: write at a leaf or read the children
		logic dn_cmp;    // sift down: compare with the smaller child and write
		logic load_out;  // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic at_root;
		logic up_move;
		logic no_child;
		logic dn_move;
	} sts_t;

endpackage

[hdl/mhpq_ram.sv]
// ----------------------------------------------------------------------------
// mhpq_ram: generic RAM, one write port and two registered read ports
// Read data appears in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

[hdl/mhpq_ctrl.sv]
// ----------------------------------------------------------------------------
// mhpq_ctrl: controller state machine of the min-heap priority queue
// Steps each request through the sift-up or sift-down walk and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  opcode_t opcode,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  sts_t    sts,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.load_out | (out_valid_q & ~m_tready);
		end
	end

	assign m_tvalid = out_valid_q;
	assign s_tready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (opcode == OP_INSERT) begin
						state_d = sts.full ? S_DONE : S_UP_CHECK;
					end else begin
						state_d = sts.empty ? S_DONE : S_RM_LOAD;
					end
				end
			end
			S_UP_CHECK: begin
				cmd.up_check = 1'b1;
				state_d = sts.at_root ? S_DONE : S_UP_CMP;
			end
			S_UP_CMP: begin
				cmd.up_cmp = 1'b1;
				state_d = sts.up_move ? S_UP_CHECK : S_DONE;
			end
			S_RM_LOAD: begin
				cmd.rm_load = 1'b1;
				state_d = S_DN_CHECK;
			end
			S_DN_CHECK: begin
				cmd.dn_check = 1'b1;
				state_d = sts.no_child ? S_DONE : S_DN_CMP;
			end
			S_DN_CMP: begin
				cmd.dn_cmp = 1'b1;
				state_d = sts.dn_move ? S_DN_CHECK : S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hdl/mhpq_dp.sv]
// ----------------------------------------------------------------------------
// mhpq_dp: datapath of the min-heap priority queue
// Holds the entry count, the moving key and its slot, the heap memory and
// the output register, and reports comparisons to the controller.
// ----------------------------------------------------------------------------
module mhpq_dp
	import mhpq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  opcode_t            opcode,
	input  logic signed [31:0] value,
	output logic signed [31:0] removed_value,
	output status_t            status,
	output logic [7:0]         count
);

	logic [CNT_W-1:0]         cnt_q;
	logic [ADDR_W-1:0]        idx_q;
	logic signed [KEY_W-1:0]  key_q;
	logic signed [KEY_W-1:0]  res_val_q;
	status_t                  res_stat_q;
	logic signed [KEY_W-1:0]  out_val_q;
	status_t                  out_stat_q;
	logic [COUNT_W-1:0]       out_cnt_q;

	logic                     we;
	logic [ADDR_W-1:0]        raddr0, raddr1;
	logic signed [KEY_W-1:0]  wdata, rd0, rd1, cval;
	logic [ADDR_W:0]          child;
	logic                     right_sel;
	logic [ADDR_W-1:0]        cidx;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	// Child slots of the current slot; the left one is always even.
	assign child     = {idx_q, 1'b0};
	assign right_sel = (child < {1'b0, cnt_q}) && (rd1 < rd0);
	assign cval      = right_sel ? rd1 : rd0;
	assign cidx      = {idx_q[ADDR_W-2:0], right_sel};

	// Status towards the controller.
	assign sts.full     = (cnt_q == CAP_C);
	assign sts.empty    = (cnt_q == '0);
	assign sts.at_root  = (idx_q == ADDR_W'(1));
	assign sts.up_move  = (key_q < rd0);
	assign sts.no_child = (child > {1'b0, cnt_q});
	assign sts.dn_move  = (key_q > cval);

	// Memory write: an entry moves into the current slot, or the key settles.
	always_comb begin
		we    = (cmd.up_check & sts.at_root) | cmd.up_cmp |
			(cmd.dn_check & sts.no_child) | cmd.dn_cmp;
		wdata = key_q;
		if (cmd.up_cmp && sts.up_move) begin
			wdata = rd0;
		end else if (cmd.dn_cmp && sts.dn_move) begin
			wdata = cval;
		end
	end

	// Read addresses: root and last slot on remove, parent or children later.
	always_comb begin
		raddr0 = ADDR_W'(1);
		raddr1 = cnt_q;
		if (cmd.up_check) begin
			raddr0 = idx_q >> 1;
		end else if (cmd.dn_check) begin
			raddr0 = {idx_q[ADDR_W-2:0], 1'b0};
			raddr1 = {idx_q[ADDR_W-2:0], 1'b1};
		end
	end

	mhpq_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_q),
		.wdata (wdata),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(rd0),
		.rdata1(rd1)
	);

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.accept) begin
			if (opcode == OP_INSERT && !sts.full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (opcode == OP_REMOVE && !sts.empty) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Moving key, its slot and the pending result.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q     <= value;
			res_val_q <= '0;
			if (opcode == OP_INSERT) begin
				idx_q      <= cnt_q + CNT_W'(1);
				res_stat_q <= sts.full ? STAT_FULL : STAT_OK;
			end else begin
				idx_q      <= ADDR_W'(1);
				res_stat_q <= sts.empty ? STAT_EMPTY : STAT_OK;
			end
		end else if (cmd.rm_load) begin
			res_val_q <= rd0;
			key_q     <= rd1;
		end else if (cmd.up_cmp && sts.up_move) begin
			idx_q <= idx_q >> 1;
		end else if (cmd.dn_cmp && sts.dn_move) begin
			idx_q <= cidx;
		end
	end

	// Output register.
	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_q};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_val_q  <= res_val_q;
			out_stat_q <= res_stat_q;
			out_cnt_q  <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign removed_value = out_val_q;
	assign status        = out_stat_q;
	assign count         = out_cnt_q;

endmodule

[hdl/min_heap_priority_queue.sv]
// ----------------------------------------------------------------------------
// min_heap_priority_queue: binary min-heap priority queue
// Inserts signed keys and removes the smallest one, one request at a time.
//
//  Channel | Direction | tdata                                | tuser
//  s_      | in        | [31:0] value                         | [0] opcode
//  m_      | out       | [31:0] removed_value, [39:32] count  | [1:0] status
//
// An insert moves its key up with a check and a compare state for each level, and a
// remove loads the root and the last entry, then moves that key down the same way;
// the key moves at most 7 levels for 255 entries.
// A full insert or an empty remove goes straight to the done state and changes nothing.
// One request is in work at a time; a stalled output holds the next result back.
// Reset clears the entry count; the heap memory needs no clearing.
// ----------------------------------------------------------------------------
module min_heap_priority_queue
	import mhpq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic        s_tuser,  // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] removed_value, [39:32] count
	output logic [1:0]  m_tuser   // [1:0] status
);

	cmd_t               cmd;
	sts_t               sts;
	opcode_t            opcode;
	logic signed [31:0] removed_value;
	status_t            status;
	logic [7:0]         count;

	assign opcode = opcode_t'(s_tuser);

	mhpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.opcode  (opcode),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	mhpq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.value        (s_tdata),
		.removed_value(removed_value),
		.status       (status),
		.count        (count)
	);

	// Pack the result request.
	assign m_tdata = {count, removed_value};
	assign m_tuser = status;

endmodule

[hdl/mhpq_chk.sv]
// ----------------------------------------------------------------------------
// mhpq_chk: port checker for the min-heap priority queue
// Watches the request and result ports and flags behaviour that the queue
// must never show.
// ----------------------------------------------------------------------------
module mhpq_chk
	import mhpq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only one request is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	// The status code is one of the three defined ones.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_EMPTY || m_tuser == STAT_FULL))
		else $error("undefined status code");

	// A remove on an empty heap returns zero and leaves it empty.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_EMPTY |-> m_tdata == 40'd0)
		else $error("bad result for remove on empty heap");

	// An insert on a full heap returns zero and reports a full count.
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_FULL |->
		m_tdata[31:0] == 32'd0 && m_tdata[39:32] == 8'(CAPACITY))
		else $error("bad result for insert on full heap");

endmodule

bind min_heap_priority_queue mhpq_chk u_chk (.*);

[verif/min_heap_priority_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_tb: self-checking bench for the min-heap queue
// Sends insert and remove requests over the input stream and keeps its own
// copy of the heap. It works out the removed key, the status and the entry
// count for every request and checks each output against them in order.
// The run covers directed edge keys, removes on an empty heap, a fill to
// capacity with inserts on a full heap, and random traffic under several
// patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_tb
	import mhpq_pkg::*;
();

	// Expected output of one request.
	typedef struct packed {
		logic signed [31:0] removed;
		status_t            status;
		logic [7:0]         count;
	} heap_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value
	logic        s_tuser;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;   // [31:0] removed_value, [39:32] count
	logic [1:0]  m_tuser;   // [1:0] status

	// Shadow heap, 1-based like the block's store.
	logic signed [31:0] heap_keys [1:CAPACITY];
	int unsigned        shadow_count;

	heap_result_t pending_results [$];
	int           error_count;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           hold_cycles_left;

	min_heap_priority_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Applies one request to the shadow heap and returns what the block should report.
	function automatic heap_result_t apply_to_heap(input opcode_t op,
		input logic signed [31:0] key);
		heap_result_t       res;
		int unsigned        slot;
		int unsigned        child;
		logic signed [31:0] last;
		logic               settled;
		res.removed = '0;
		res.status  = STAT_OK;
		if (op == OP_INSERT) begin
			if (shadow_count >= CAPACITY) begin
				res.status = STAT_FULL;
			end else begin
				// Sift up while strictly smaller than the parent.
				shadow_count = shadow_count + 1;
				slot = shadow_count;
				while (slot > 1 && key < heap_keys[slot / 2]) begin
					heap_keys[slot] = heap_keys[slot / 2];
					slot = slot / 2;
				end
				heap_keys[slot] = key;
			end
		end else begin
			if (shadow_count == 0) begin
				res.status = STAT_EMPTY;
			end else begin
				// Take the root, then sift the last entry down from the top.
				res.removed = heap_keys[1];
				last = heap_keys[shadow_count];
				shadow_count = shadow_count - 1;
				slot = 1;
				child = 2;
				settled = 1'b0;
				while (child <= shadow_count && !settled) begin
					if (child < shadow_count && heap_keys[child + 1] < heap_keys[child])
						child = child + 1;
					if (last <= heap_keys[child]) begin
						settled = 1'b1;
					end else begin
						heap_keys[slot] = heap_keys[child];
						slot = child;
						child = child * 2;
					end
				end
				heap_keys[slot] = last;
			end
		end
		res.count = shadow_count[7:0];
		return res;
	endfunction

	// Offers one request, with an optional gap first, and records its expected result.
	task automatic send_request(input opcode_t op, input logic [31:0] key);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_to_heap(op, key));
	endtask

	// Stops offering and waits until every outstanding result has been seen.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Key mix: full range, a narrow band that forces ties, and the extremes.
	function automatic logic [31:0] pick_key();
		logic [31:0] key;
		case ($urandom_range(3))
			0:       key = 32'($urandom_range(7)) - 32'd4;
			1:       key = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: key = $urandom;
		endcase
		return key;
	endfunction

	// Receiver: random stalls, or a long hold-off counted down here.
	always @(posedge clk) begin
		if (hold_cycles_left != 0) begin
			m_tready <= 1'b0;
			hold_cycles_left = hold_cycles_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_output(input heap_result_t want);
		if (m_tdata[31:0] !== want.removed) begin
			$display("%0t: removed_value expected %0d actual %0d",
				$realtime, want.removed, $signed(m_tdata[31:0]));
			error_count = error_count + 1;
		end
		if (m_tuser !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $realtime, want.status, m_tuser);
			error_count = error_count + 1;
		end
		if (m_tdata[39:32] !== want.count) begin
			$display("%0t: count expected %0d actual %0d",
				$realtime, want.count, m_tdata[39:32]);
			error_count = error_count + 1;
		end
	endtask

	// Compares each accepted output with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: output with nothing expected: removed %0d status %0d count %0d",
					$realtime, $signed(m_tdata[31:0]), m_tuser, m_tdata[39:32]);
				error_count = error_count + 1;
			end else begin
				check_output(pending_results.pop_front());
			end
		end
	end

	// Edge keys, duplicates and removes past empty, with no idling.
	task automatic test_directed();
		logic [31:0] edge_keys [10];
		edge_keys = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1,
			32'd5, 32'd5, 32'hFFFF_FFFB, 32'h8000_0000, 32'h7FFF_FFFF};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(OP_REMOVE, 32'hFFFF_FFFF);
		foreach (edge_keys[i])
			send_request(OP_INSERT, edge_keys[i]);
		// The value field is ignored on removes, so it alternates here.
		for (int i = 0; i < 11; i++)
			send_request(OP_REMOVE, (i % 2) ? 32'hFFFF_FFFF : 32'd0);
		wait_drained();
	endtask

	// Fills the heap to capacity behind a long receiver hold-off, then drains it.
	task automatic test_fill_and_drain();
		send_idle_pct  = 0;
		recv_stall_pct = 20;
		hold_cycles_left = 400;
		while (shadow_count < CAPACITY)
			send_request(OP_INSERT, pick_key());
		for (int i = 0; i < 3; i++)
			send_request(OP_INSERT, $urandom);
		send_request(OP_REMOVE, $urandom);
		send_request(OP_INSERT, 32'h8000_0000);
		send_request(OP_INSERT, 32'd0);
		while (shadow_count != 0)
			send_request(OP_REMOVE, $urandom);
		send_request(OP_REMOVE, $urandom);
		wait_drained();
	endtask

	// Random requests: the heap grows over the first half and shrinks over the second.
	task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
		int insert_pct;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++) begin
			insert_pct = (i < n_items / 2) ? 65 : 35;
			if ($urandom_range(99) < insert_pct)
				send_request(OP_INSERT, pick_key());
			else
				send_request(OP_REMOVE, $urandom);
		end
		wait_drained();
	endtask

	initial begin
		arst_n           = 1'b0;
		s_tvalid         = 1'b0;
		s_tdata          = '0;
		s_tuser          = 1'b0;
		shadow_count     = 0;
		error_count      = 0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		hold_cycles_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_random(0, 0, 120);
		test_random(46, 0, 120);
		test_random(0, 46, 120);
		test_random(10, 10, 120);

		// Let any stray output show up before the verdict.
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("min_heap_priority_queue_tb: clean");
		else
			$display("min_heap_priority_queue_tb: errors");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5_000_000;
		$display("min_heap_priority_queue_tb: errors");
		$finish;
	end

endmodule

[files.f]
hdl/mhpq_pkg.sv
hdl/mhpq_ram.sv
hdl/mhpq_ctrl.sv
hdl/mhpq_dp.sv
hdl/min_heap_priority_queue.sv
hdl/mhpq_chk.sv
verif/min_heap_priority_queue_tb.sv
